FILE: src/epq_pkg.sv
// ----------------------------------------------------------------------------
// epq_pkg
// Shared types and constants of the pending-event queue.
// ----------------------------------------------------------------------------
package epq_pkg;

    localparam int QueueDepth = 64;
    localparam int SlotW      = $clog2(QueueDepth);
    localparam int CountW     = $clog2(QueueDepth + 1);

    localparam logic [1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [1:0] ACT_CANCEL   = 2'd1;
    localparam logic [1:0] ACT_DISPATCH = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_EMPTY       = 2'd2;
    localparam logic [1:0] ST_NOT_PENDING = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] event_time;
        logic [7:0]  event_code;
        logic [15:0] event_index;
        logic [31:0] attachment;
        logic [31:0] cancel_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [31:0] out_time;
        logic [7:0]  out_code;
        logic [15:0] out_index;
        logic [31:0] out_attachment;
        logic [31:0] now_time;
    } t_rsp;

    // Slot payload kept in the memory.
    typedef struct packed {
        logic [31:0] time_v;
        logic [31:0] id;
        logic [7:0]  code;
        logic [15:0] index;
        logic [31:0] attachment;
    } t_entry;

endpackage

FILE: src/epq_if.sv
// ----------------------------------------------------------------------------
// epq_req_if / epq_rsp_if
// Valid/ready channels of the pending-event queue.
// ----------------------------------------------------------------------------
interface epq_req_if;
    import epq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface epq_rsp_if;
    import epq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/event_priority_queue_with_cancel.sv
// ----------------------------------------------------------------------------
// event_priority_queue_with_cancel
// Time-ordered pending-event queue with schedule, cancel and dispatch.
// ----------------------------------------------------------------------------
// channel   dir  payload
// i_req     in   action, event_time, event_code, event_index, attachment,
//                cancel_id
// o_rsp     out  status, result_id, out_time, out_code, out_index,
//                out_attachment, now_time
//
// A schedule item resolves from the valid bits; its result is registered
// and offered in the cycle after the transfer. Cancel, dispatch and the
// unused action walk all slots of the memory, one read per cycle; the scan
// is paced by the single read port of the slot memory. Reset is
// synchronous, active low, clears the valid bits and current time, and
// sets the id counter to 1. A waiting result holds off the next transfer.
// ----------------------------------------------------------------------------
module event_priority_queue_with_cancel (
    input  logic      i_clk,
    input  logic      i_rst_n,
    epq_req_if.sink   i_req,
    epq_rsp_if.source o_rsp
);
    import epq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    t_entry r_mem [QueueDepth];
    t_entry r_rd;
    logic [QueueDepth-1:0] r_valid;

    logic [1:0]        r_state;
    t_req              r_req;
    logic [CountW-1:0] r_addr;      // read address issued
    logic [SlotW-1:0]  r_cmp;       // slot whose data is in r_rd
    logic              r_rd_live;
    logic              r_found;
    logic [SlotW-1:0]  r_pick;
    t_entry            r_best;
    logic [31:0]       r_next_id;
    logic [31:0]       r_now;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [SlotW-1:0] free_slot;
    logic             any_free;
    logic             take;
    logic             hit;
    logic             wr_en;
    t_entry           wr_data;
    t_rsp             n_out;
    t_rsp             n_sched;

    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign take        = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Lowest free slot from the valid bits.
    always_comb begin
        free_slot = '0;
        any_free  = 1'b0;
        for (int i = QueueDepth - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SlotW'(i);
                any_free  = 1'b1;
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        if (r_rd_live && r_valid[r_cmp]) begin
            case (r_req.action)
                ACT_CANCEL: hit = !r_found && (r_rd.id == r_req.cancel_id);
                ACT_DISPATCH: hit = !r_found || (r_rd.time_v < r_best.time_v) ||
                    ((r_rd.time_v == r_best.time_v) && (r_rd.id < r_best.id));
                default: hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        wr_en   = take && (i_req.data.action == ACT_SCHEDULE) && any_free;
        wr_data = '{time_v: i_req.data.event_time, id: r_next_id,
                    code: i_req.data.event_code, index: i_req.data.event_index,
                    attachment: i_req.data.attachment};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[free_slot] <= wr_data;
        end
        r_rd <= r_mem[r_addr[SlotW-1:0]];
    end

    always_comb begin
        n_sched = '0;
        n_sched.now_time = r_now;
        if (any_free) begin
            n_sched.result_id = r_next_id;
        end else begin
            n_sched.status = ST_FULL;
        end
    end

    always_comb begin
        n_out = '0;
        n_out.now_time = r_now;
        case (r_req.action)
            ACT_CANCEL: begin
                n_out.status    = r_found ? ST_OK : ST_NOT_PENDING;
                n_out.result_id = r_found ? r_req.cancel_id : 32'd0;
            end
            ACT_DISPATCH: begin
                if (r_found) begin
                    n_out.result_id      = r_best.id;
                    n_out.out_time       = r_best.time_v;
                    n_out.out_code       = r_best.code;
                    n_out.out_index      = r_best.index;
                    n_out.out_attachment = r_best.attachment;
                    n_out.now_time       = r_best.time_v;
                end else begin
                    n_out.status = ST_EMPTY;
                end
            end
            default: n_out = '0;
        endcase
        if (r_req.action == ACT_SCHEDULE || r_req.action == ACT_RESERVED) begin
            n_out.now_time = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_next_id   <= 32'd1;
            r_now       <= '0;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
            r_cmp       <= '0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_live <= 1'b0;
                    if (take) begin
                        r_req <= i_req.data;
                        if (i_req.data.action == ACT_SCHEDULE) begin
                            // Schedule resolves at once from the valid bits.
                            r_out_valid <= 1'b1;
                            r_out       <= n_sched;
                            if (any_free) begin
                                r_valid[free_slot] <= 1'b1;
                                r_next_id <= (r_next_id == 32'hFFFF_FFFF) ? 32'd1
                                                                          : r_next_id + 32'd1;
                            end
                        end else begin
                            r_addr  <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue reads; compare the slot read the cycle before.
                    r_cmp     <= r_addr[SlotW-1:0];
                    r_rd_live <= (r_addr < CountW'(QueueDepth));
                    if (r_addr < CountW'(QueueDepth)) begin
                        r_addr <= r_addr + CountW'(1);
                    end else if (!r_rd_live) begin
                        r_state <= S_FIN;
                    end
                    if (hit) begin
                        r_found <= 1'b1;
                        r_pick  <= r_cmp;
                        r_best  <= r_rd;
                    end
                end
                S_FIN: begin
                    if (r_found && (r_req.action == ACT_CANCEL ||
                                    r_req.action == ACT_DISPATCH)) begin
                        r_valid[r_pick] <= 1'b0;
                    end
                    if (r_found && r_req.action == ACT_DISPATCH) begin
                        r_now <= r_best.time_v;
                    end
                    r_out       <= n_out;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
